// File: hdl/gce_pkg.sv
// Shared types, constants and arithmetic helpers for the gamma Chebyshev evaluator.
// Holds the series coefficients in Q2.30, worked out at elaboration.
// No dependencies.
package gce_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned FRAC_BITS  = 30;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PADDR_W    = 3;

  // register index of full_terms, decoded from paddr[2]
  localparam logic REG_FULL_TERMS = 1'b0;

  localparam int unsigned NUM_ITER    = 7;
  localparam int unsigned SHORT_TERMS = 5;

  // pipeline stage indices
  localparam int unsigned ST_IN   = 0;
  localparam int unsigned ST_SQ   = 1;
  localparam int unsigned ST_T    = 2;
  localparam int unsigned ST_ITER = 3;
  localparam int unsigned ST_FM   = ST_ITER + 2 * NUM_ITER;
  localparam int unsigned ST_FA   = ST_FM + 1;
  localparam int unsigned ST_XM   = ST_FA + 1;
  localparam int unsigned NUM_STG = ST_XM + 1;

  typedef logic signed [DATA_W-1:0]        fix_t;
  typedef logic        [DATA_W-1:0]        mag_t;
  typedef logic signed [DATA_W:0]          y2_t;
  typedef logic signed [2*DATA_W:0]        prod_t;
  typedef logic signed [2*DATA_W-FRAC_BITS:0] rnd_t;
  typedef logic signed [DATA_W+3:0]        wide_t;
  typedef logic        [2*DATA_W-1:0]      sq_t;

  localparam mag_t HALF_MAG = mag_t'(64'd1 << (FRAC_BITS - 1));
  localparam mag_t ONE_MAG  = mag_t'(64'd1 << FRAC_BITS);
  localparam sq_t  T_ROUND  = sq_t'(64'd1 << (FRAC_BITS - 4));

  localparam logic [63:0] COEF_DEN = 64'd100000000000000000;

  typedef struct packed {
    fix_t  x;
    logic  oor;
    sq_t   sq;
    fix_t  t;
    fix_t  d1;
    fix_t  dd1;
    fix_t  d2;
    fix_t  dd2;
    prod_t p1;
    prod_t p2;
  } pipe_t;

  typedef struct packed {
    fix_t gamma_one;
    fix_t gamma_two;
    fix_t recip_gamma_plus;
    fix_t recip_gamma_minus;
    logic out_of_range;
  } result_t;

  // magnitude / 10^17 as a rounded 60-bit binary fraction
  function automatic logic [63:0] q60_mag(input logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] r;
    acc = m / COEF_DEN;
    r   = m % COEF_DEN;
    for (int i = 0; i < 61; i++) begin
      r   = r << 1;
      acc = acc << 1;
      if (r >= COEF_DEN) begin
        acc = acc | 64'd1;
        r   = r - COEF_DEN;
      end
    end
    return (acc + 64'd1) >> 1;
  endfunction

  function automatic fix_t coef_fix(input longint man, input int unsigned extra);
    logic [63:0]  v;
    int unsigned  s;
    v = q60_mag(man < 0 ? 64'(-man) : 64'(man));
    s = (60 - FRAC_BITS) + extra;
    v = (v + (64'd1 << (s - 1))) >> s;
    return man < 0 ? fix_t'(-v) : fix_t'(v);
  endfunction

  localparam fix_t G1_HALF = coef_fix(-64'sd114202268037116800, 1);
  localparam fix_t G2_HALF = coef_fix(64'sd184374058730090500, 1);

  localparam fix_t G1_C [1:NUM_ITER] = '{
    coef_fix(64'sd651651126707370, 0),
    coef_fix(64'sd30870901730860, 0),
    coef_fix(-64'sd347062696490, 0),
    coef_fix(64'sd694376640, 0),
    coef_fix(64'sd3677950, 0),
    coef_fix(-64'sd13560, 0),
    fix_t'(0)
  };

  localparam fix_t G2_C [1:NUM_ITER] = '{
    coef_fix(-64'sd7685284084478670, 0),
    coef_fix(64'sd127192713665460, 0),
    coef_fix(-64'sd497173670420, 0),
    coef_fix(-64'sd3312611980, 0),
    coef_fix(64'sd24230960, 0),
    coef_fix(-64'sd17020, 0),
    coef_fix(-64'sd149, 0)
  };

  // product scaled down by 2^FRAC_BITS, rounded half away from zero
  function automatic rnd_t fmul_round(input prod_t p);
    logic [2*DATA_W:0] mag;
    logic [2*DATA_W:0] sum;
    rnd_t              r;
    mag = p[2*DATA_W] ? (2*DATA_W+1)'(-p) : (2*DATA_W+1)'(p);
    sum = mag + (2*DATA_W+1)'(HALF_MAG);
    r   = rnd_t'(sum[2*DATA_W:FRAC_BITS]);
    return p[2*DATA_W] ? -r : r;
  endfunction

  function automatic fix_t sat32(input wide_t v);
    if (v > wide_t'(fix_t'({1'b0, {(DATA_W-1){1'b1}}}))) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
    if (v < wide_t'(fix_t'({1'b1, {(DATA_W-1){1'b0}}}))) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end
    return fix_t'(v);
  endfunction

endpackage

// File: hdl/gce_req_if.sv
// Request channel of the gamma Chebyshev evaluator: valid/ready and argument x.
// Depends on gce_pkg.
interface gce_req_if import gce_pkg::*; ();
  logic valid;
  logic ready;
  fix_t x_value;

  modport source (output valid, output x_value, input ready);
  modport sink (input valid, input x_value, output ready);
endinterface

// File: hdl/gce_rsp_if.sv
// Result channel of the gamma Chebyshev evaluator: valid/ready and the five result fields.
// Depends on gce_pkg.
interface gce_rsp_if import gce_pkg::*; ();
  logic valid;
  logic ready;
  fix_t gamma_one;
  fix_t gamma_two;
  fix_t recip_gamma_plus;
  fix_t recip_gamma_minus;
  logic out_of_range;

  modport source (output valid, output gamma_one, output gamma_two,
                  output recip_gamma_plus, output recip_gamma_minus,
                  output out_of_range, input ready);
  modport sink (input valid, input gamma_one, input gamma_two,
                input recip_gamma_plus, input recip_gamma_minus,
                input out_of_range, output ready);
endinterface

// File: hdl/gamma_chebyshev_eval_top.sv
// Gamma1/Gamma2 Chebyshev evaluator, top level. Depends on gce_pkg, gce_req_if, gce_rsp_if.
// An accepted request's result lands in the output register after the last pipeline stage.
// Throughput: one request per cycle while the output is not stalled; 20 pipeline stages plus the output register,
// one Clenshaw step every two stages (multiply, then round and accumulate).
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and sets full_terms to 1.
module gamma_chebyshev_eval_top import gce_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  gce_req_if.sink               req_i,
  gce_rsp_if.source             rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic                 full_terms_q;
  logic [NUM_STG-1:0]   vld_q;
  logic                 out_vld_q;
  logic                 advance;
  pipe_t                stg_q [NUM_STG];
  pipe_t                stg_d [NUM_STG];
  result_t              out_q;
  result_t              out_d;

  mag_t                 ax;
  sq_t                  sq_rnd;
  mag_t                 tp;
  y2_t                  y2;
  rnd_t                 r1;
  rnd_t                 r2;
  rnd_t                 xg;
  logic                 use_c;

  // configuration port
  assign pready = 1'b1;
  assign prdata = CFG_DATA_W'(full_terms_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_terms_q <= 1'b1;
    end else if (psel && penable && pwrite && (paddr[2] == REG_FULL_TERMS)) begin
      full_terms_q <= pwdata[0];
    end
  end

  // advance everything unless a result waits at the output and is not taken
  assign advance     = !out_vld_q || rsp_o.ready;
  assign req_i.ready = advance;

  always_comb begin
    r1     = '0;
    r2     = '0;
    y2     = '0;
    use_c  = 1'b0;

    stg_d[ST_IN]   = stg_q[ST_IN];
    stg_d[ST_IN].x = req_i.x_value;

    stg_d[ST_SQ]     = stg_q[ST_IN];
    ax               = stg_q[ST_IN].x[DATA_W-1] ? mag_t'(-stg_q[ST_IN].x)
                                                : mag_t'(stg_q[ST_IN].x);
    stg_d[ST_SQ].oor = ax > HALF_MAG;
    stg_d[ST_SQ].sq  = sq_t'(ax) * sq_t'(ax);

    stg_d[ST_T]     = stg_q[ST_SQ];
    sq_rnd          = stg_q[ST_SQ].sq + T_ROUND;
    tp              = sq_rnd[FRAC_BITS+DATA_W-4:FRAC_BITS-3];
    stg_d[ST_T].t   = fix_t'(tp - ONE_MAG);
    stg_d[ST_T].d1  = '0;
    stg_d[ST_T].dd1 = '0;
    stg_d[ST_T].d2  = '0;
    stg_d[ST_T].dd2 = '0;

    for (int k = 0; k < NUM_ITER; k++) begin
      stg_d[ST_ITER+2*k]    = stg_q[ST_ITER+2*k-1];
      y2                    = y2_t'({stg_q[ST_ITER+2*k-1].t, 1'b0});
      stg_d[ST_ITER+2*k].p1 = prod_t'(y2) * prod_t'(stg_q[ST_ITER+2*k-1].d1);
      stg_d[ST_ITER+2*k].p2 = prod_t'(y2) * prod_t'(stg_q[ST_ITER+2*k-1].d2);

      use_c = full_terms_q || ((NUM_ITER - k) < SHORT_TERMS);
      r1    = fmul_round(stg_q[ST_ITER+2*k].p1);
      r2    = fmul_round(stg_q[ST_ITER+2*k].p2);
      stg_d[ST_ITER+2*k+1]     = stg_q[ST_ITER+2*k];
      stg_d[ST_ITER+2*k+1].d1  = fix_t'(r1) - stg_q[ST_ITER+2*k].dd1
                                 + (use_c ? G1_C[NUM_ITER-k] : fix_t'(0));
      stg_d[ST_ITER+2*k+1].d2  = fix_t'(r2) - stg_q[ST_ITER+2*k].dd2
                                 + (use_c ? G2_C[NUM_ITER-k] : fix_t'(0));
      stg_d[ST_ITER+2*k+1].dd1 = stg_q[ST_ITER+2*k].d1;
      stg_d[ST_ITER+2*k+1].dd2 = stg_q[ST_ITER+2*k].d2;
    end

    stg_d[ST_FM]    = stg_q[ST_FM-1];
    stg_d[ST_FM].p1 = prod_t'(stg_q[ST_FM-1].t) * prod_t'(stg_q[ST_FM-1].d1);
    stg_d[ST_FM].p2 = prod_t'(stg_q[ST_FM-1].t) * prod_t'(stg_q[ST_FM-1].d2);

    stg_d[ST_FA]    = stg_q[ST_FM];
    stg_d[ST_FA].d1 = fix_t'(fmul_round(stg_q[ST_FM].p1)) - stg_q[ST_FM].dd1 + G1_HALF;
    stg_d[ST_FA].d2 = fix_t'(fmul_round(stg_q[ST_FM].p2)) - stg_q[ST_FM].dd2 + G2_HALF;

    stg_d[ST_XM]    = stg_q[ST_FA];
    stg_d[ST_XM].p1 = prod_t'(stg_q[ST_FA].x) * prod_t'(stg_q[ST_FA].d1);

    xg = fmul_round(stg_q[ST_XM].p1);
    if (stg_q[ST_XM].oor) begin
      out_d.gamma_one         = '0;
      out_d.gamma_two         = '0;
      out_d.recip_gamma_plus  = '0;
      out_d.recip_gamma_minus = '0;
      out_d.out_of_range      = 1'b1;
    end else begin
      out_d.gamma_one         = stg_q[ST_XM].d1;
      out_d.gamma_two         = stg_q[ST_XM].d2;
      out_d.recip_gamma_plus  = sat32(wide_t'(stg_q[ST_XM].d2) - wide_t'(xg));
      out_d.recip_gamma_minus = sat32(wide_t'(stg_q[ST_XM].d2) + wide_t'(xg));
      out_d.out_of_range      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      vld_q     <= {vld_q[NUM_STG-2:0], req_i.valid};
      out_vld_q <= vld_q[NUM_STG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      stg_q <= stg_d;
      out_q <= out_d;
    end
  end

  assign rsp_o.valid             = out_vld_q;
  assign rsp_o.gamma_one         = out_q.gamma_one;
  assign rsp_o.gamma_two         = out_q.gamma_two;
  assign rsp_o.recip_gamma_plus  = out_q.recip_gamma_plus;
  assign rsp_o.recip_gamma_minus = out_q.recip_gamma_minus;
  assign rsp_o.out_of_range      = out_q.out_of_range;

endmodule
